### src/iirdf2_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iirdf2_pkg
// Shared types and constants of the direct form II IIR filter core.
// ----------------------------------------------------------------------------
package iirdf2_pkg;

	localparam int TAP_COUNT_DEF = 4;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int W_W      = 24;
	localparam int RING_W   = 2;
	localparam int CFG_IDX_W = 3;
	localparam int COEF_NUM  = 7;
	localparam int FRAC_BITS = 13;
	localparam int PROD_W    = COEF_W + W_W;
	localparam int ACC_W     = PROD_W + 4;
	localparam int TAP_W     = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_NUM0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEN1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEN2 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DEN3 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST = CFG_DEN3;

	localparam logic signed [COEF_W-1:0] NUM0_RESET = 16'sd8192;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FB1,
		ST_FB2,
		ST_FB3,
		ST_FB_ACC,
		ST_W_WR,
		ST_FF0,
		ST_FF1,
		ST_FF2,
		ST_FF3,
		ST_FF_ACC,
		ST_EMIT
	} step_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD_X,
		ACC_CLEAR,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_WAIT_IN,
		JMP_WAIT_OUT
	} jmp_t;

	// one microcode word
	typedef struct packed {
		jmp_t                  jmp;
		logic                  to_target;
		step_t                 target;
		logic                  cap_in;
		acc_op_t               acc_op;
		logic                  mul_en;
		logic [CFG_IDX_W-1:0]  coef_sel;
		logic [TAP_W-1:0]      tap;
		logic                  w_wr;
		logic                  out_ld;
		logic                  advance;
	} uword_t;

	// gated controls toward the datapath
	typedef struct packed {
		logic                  cap_in;
		acc_op_t               acc_op;
		logic                  mul_en;
		logic [CFG_IDX_W-1:0]  coef_sel;
		logic [TAP_W-1:0]      tap;
		logic                  w_wr;
		logic                  out_ld;
		logic                  advance;
	} dp_ctrl_t;

	// datapath status toward the sequencer
	typedef struct packed {
		logic              out_free;
		logic [RING_W-1:0] ring;
	} dp_stat_t;

	function automatic uword_t ucode_rom(input step_t pc);
		uword_t u;
		u = '{jmp: JMP_NEXT, to_target: 1'b0, target: ST_IDLE, cap_in: 1'b0,
			acc_op: ACC_HOLD, mul_en: 1'b0, coef_sel: CFG_NUM0, tap: 2'd0,
			w_wr: 1'b0, out_ld: 1'b0, advance: 1'b0};
		case (pc)
			ST_IDLE: begin
				u.jmp    = JMP_WAIT_IN;
				u.cap_in = 1'b1;
			end
			ST_FB1: begin
				u.acc_op   = ACC_LOAD_X;
				u.mul_en   = 1'b1;
				u.coef_sel = CFG_DEN1;
				u.tap      = 2'd1;
			end
			ST_FB2: begin
				u.acc_op   = ACC_SUB;
				u.mul_en   = 1'b1;
				u.coef_sel = CFG_DEN2;
				u.tap      = 2'd2;
			end
			ST_FB3: begin
				u.acc_op   = ACC_SUB;
				u.mul_en   = 1'b1;
				u.coef_sel = CFG_DEN3;
				u.tap      = 2'd3;
			end
			ST_FB_ACC: begin
				u.acc_op = ACC_SUB;
			end
			ST_W_WR: begin
				u.w_wr   = 1'b1;
				u.acc_op = ACC_CLEAR;
			end
			ST_FF0: begin
				u.mul_en   = 1'b1;
				u.coef_sel = CFG_NUM0;
				u.tap      = 2'd0;
			end
			ST_FF1: begin
				u.acc_op   = ACC_ADD;
				u.mul_en   = 1'b1;
				u.coef_sel = CFG_NUM1;
				u.tap      = 2'd1;
			end
			ST_FF2: begin
				u.acc_op   = ACC_ADD;
				u.mul_en   = 1'b1;
				u.coef_sel = CFG_NUM2;
				u.tap      = 2'd2;
			end
			ST_FF3: begin
				u.acc_op   = ACC_ADD;
				u.mul_en   = 1'b1;
				u.coef_sel = CFG_NUM3;
				u.tap      = 2'd3;
			end
			ST_FF_ACC: begin
				u.acc_op = ACC_ADD;
			end
			ST_EMIT: begin
				u.jmp       = JMP_WAIT_OUT;
				u.out_ld    = 1'b1;
				u.advance   = 1'b1;
				u.to_target = 1'b1;
				u.target    = ST_IDLE;
			end
			default: begin
				u.to_target = 1'b1;
				u.target    = ST_IDLE;
			end
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

### src/iirdf2_filter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iir_direct_form_two_filter_core
// Direct form II IIR filter, Q2.13 coefficients, microcoded single MAC.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one input sample per beat (tdata = sample, tlast = block end).
//   m_axis returns one filtered sample per input beat, tlast copied through.
//   cfg writes coefficient registers: index 0..3 = b0..b3, 4..6 = a1..a3;
//   cfg_ready is always high, other indexes are dropped. Write only when idle.
// Timing:
//   A 12-step microprogram runs per sample on one shared 16x24 multiplier:
//   one idle/accept step, feedback taps, w write, feedforward taps, emit.
//   Samples are taken one at a time: the next sample is accepted only when
//   the program is back at its idle step.
//   The output register frees the input side: the next sample is accepted
//   while a result still waits on m_axis. A stall holds the program at its
//   emit step until the output register drains.
// Reset:
//   arst_n clears the w history, ring position and output valid, and sets
//   b0 = 1.0 with all other coefficients zero.
// ----------------------------------------------------------------------------
module iir_direct_form_two_filter_core #(
	parameter int TAP_COUNT = iirdf2_pkg::TAP_COUNT_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [15:0]                         s_axis_tdata,  // [15:0] sample_in
	input  wire logic                                s_axis_tlast,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [15:0]                              m_axis_tdata,  // [15:0] sample_out
	output logic                                     m_axis_tlast,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [iirdf2_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [iirdf2_pkg::COEF_W-1:0]       cfg_data
);
	import iirdf2_pkg::*;

	step_t    pc;
	dp_ctrl_t ctrl;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	iirdf2_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.stat     (stat),
		.pc       (pc),
		.in_ready (s_axis_tready),
		.ctrl     (ctrl)
	);

	iirdf2_dp #(
		.TAP_COUNT (TAP_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_val   (cfg_data),
		.x_in      (s_axis_tdata),
		.last_in   (s_axis_tlast),
		.out_ack   (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.y_out     (m_axis_tdata),
		.last_out  (m_axis_tlast),
		.stat      (stat)
	);

	a_emit_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(pc == ST_EMIT))
		else $error("output valid rose outside emit step");

	a_one_in: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted twice in a row");

	a_ring: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, stat.ring} < 3'(TAP_COUNT))
		else $error("ring position out of range");

endmodule
`default_nettype wire

### src/iirdf2_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iirdf2_seq
// Step counter and microcode table; holds on input and output waits.
// ----------------------------------------------------------------------------
module iirdf2_seq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire iirdf2_pkg::dp_stat_t  stat,
	output iirdf2_pkg::step_t          pc,
	output logic                       in_ready,
	output iirdf2_pkg::dp_ctrl_t       ctrl
);
	import iirdf2_pkg::*;

	step_t  pc_q;
	step_t  pc_nxt;
	uword_t uw;
	logic   hold;
	logic   in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_nxt;
		end
	end

	always_comb begin
		uw       = ucode_rom(pc_q);
		in_ready = (uw.jmp == JMP_WAIT_IN);
		in_fire  = in_ready && in_valid;
		case (uw.jmp)
			JMP_WAIT_IN:  hold = !in_valid;
			JMP_WAIT_OUT: hold = !stat.out_free;
			default:      hold = 1'b0;
		endcase
		if (hold) begin
			pc_nxt = pc_q;
		end else if (uw.to_target) begin
			pc_nxt = uw.target;
		end else begin
			pc_nxt = step_t'(pc_q + 4'd1);
		end
		ctrl.cap_in   = uw.cap_in && in_fire;
		ctrl.acc_op   = uw.acc_op;
		ctrl.mul_en   = uw.mul_en;
		ctrl.coef_sel = uw.coef_sel;
		ctrl.tap      = uw.tap;
		ctrl.w_wr     = uw.w_wr;
		ctrl.out_ld   = uw.out_ld && !hold;
		ctrl.advance  = uw.advance && !hold;
	end

	assign pc = pc_q;

endmodule
`default_nettype wire

### src/iirdf2_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iirdf2_dp
// Coefficient registers, w ring, shared multiplier, accumulator, rounding,
// saturation and output register.
// ----------------------------------------------------------------------------
module iirdf2_dp #(
	parameter int TAP_COUNT = iirdf2_pkg::TAP_COUNT_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire iirdf2_pkg::dp_ctrl_t                   ctrl,
	input  wire logic                                   cfg_wr,
	input  wire logic [iirdf2_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire logic [iirdf2_pkg::COEF_W-1:0]          cfg_val,
	input  wire logic [iirdf2_pkg::SAMPLE_W-1:0]        x_in,
	input  wire logic                                   last_in,
	input  wire logic                                   out_ack,
	output logic                                        out_valid,
	output logic [iirdf2_pkg::SAMPLE_W-1:0]             y_out,
	output logic                                        last_out,
	output iirdf2_pkg::dp_stat_t                        stat
);
	import iirdf2_pkg::*;

	localparam int HIDX_W = (TAP_COUNT > 2) ? $clog2(TAP_COUNT) : 1;
	localparam int RND_W  = ACC_W + 1;
	localparam int R_W    = RND_W - FRAC_BITS;

	logic signed [COEF_W-1:0]   coef_q [COEF_NUM];
	logic signed [W_W-1:0]      hist_q [TAP_COUNT];
	logic [RING_W-1:0]          ring_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic                       last_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       out_valid_q;
	logic [SAMPLE_W-1:0]        y_q;
	logic                       last_out_q;

	logic [2:0]                 head;
	logic [2:0]                 rd_sum;
	logic [2:0]                 rd_wrap;
	logic [HIDX_W-1:0]          rd_idx;
	logic [HIDX_W-1:0]          wr_idx;
	logic                       tap_live;
	logic signed [RND_W-1:0]    rnd;
	logic signed [R_W-1:0]      r;
	logic signed [W_W-1:0]      w_sat;
	logic signed [SAMPLE_W-1:0] y_sat;
	logic                       out_free;

	always_comb begin
		head     = 3'(TAP_COUNT - 1) - {1'b0, ring_q};
		rd_sum   = head + {1'b0, ctrl.tap};
		rd_wrap  = (rd_sum >= 3'(TAP_COUNT)) ? rd_sum - 3'(TAP_COUNT) : rd_sum;
		rd_idx   = rd_wrap[HIDX_W-1:0];
		wr_idx   = head[HIDX_W-1:0];
		tap_live = ({1'b0, ctrl.tap} < 3'(TAP_COUNT));
		rnd      = RND_W'(acc_q) + RND_W'(4096);
		r        = rnd[RND_W-1:FRAC_BITS];
		if (r > R_W'(8388607)) begin
			w_sat = 24'sh7FFFFF;
		end else if (r < -R_W'(8388608)) begin
			w_sat = 24'sh800000;
		end else begin
			w_sat = r[W_W-1:0];
		end
		if (r > R_W'(32767)) begin
			y_sat = 16'sh7FFF;
		end else if (r < -R_W'(32768)) begin
			y_sat = 16'sh8000;
		end else begin
			y_sat = r[SAMPLE_W-1:0];
		end
		out_free = !out_valid_q || out_ack;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_NUM; i++) begin
				coef_q[i] <= '0;
			end
			coef_q[CFG_NUM0] <= NUM0_RESET;
		end else if (cfg_wr && cfg_idx <= CFG_LAST) begin
			coef_q[cfg_idx] <= cfg_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAP_COUNT; i++) begin
				hist_q[i] <= '0;
			end
			ring_q <= '0;
		end else begin
			if (ctrl.w_wr) begin
				hist_q[wr_idx] <= w_sat;
			end
			if (ctrl.advance) begin
				ring_q <= (ring_q == RING_W'(TAP_COUNT - 1)) ? '0 : ring_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cap_in) begin
			x_q    <= x_in;
			last_q <= last_in;
		end
		if (ctrl.mul_en) begin
			prod_q <= tap_live ? PROD_W'(coef_q[ctrl.coef_sel] * hist_q[rd_idx]) : '0;
		end
		case (ctrl.acc_op)
			ACC_LOAD_X: acc_q <= ACC_W'(x_q) <<< FRAC_BITS;
			ACC_CLEAR:  acc_q <= '0;
			ACC_ADD:    acc_q <= acc_q + ACC_W'(prod_q);
			ACC_SUB:    acc_q <= acc_q - ACC_W'(prod_q);
			default:    acc_q <= acc_q;
		endcase
		if (ctrl.out_ld) begin
			y_q        <= y_sat;
			last_out_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ack) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign y_out     = y_q;
	assign last_out  = last_out_q;
	assign stat      = '{out_free: out_free, ring: ring_q};

endmodule
`default_nettype wire

### bench/iirdf2_check.sv
// ----------------------------------------------------------------------------
// iirdf2_check
// Watches the sample, result and coefficient channels of the direct form II
// filter core. Keeps its own copy of the coefficients and of the w history,
// predicts every filtered sample at input accept time and compares each
// output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module iirdf2_check #(
	parameter int TAPS = iirdf2_pkg::TAP_COUNT_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	input  wire logic                             s_axis_tready,
	input  wire logic [15:0]                      s_axis_tdata,
	input  wire logic                             s_axis_tlast,
	input  wire logic                             m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	input  wire logic [15:0]                      m_axis_tdata,
	input  wire logic                             m_axis_tlast,
	input  wire logic                             cfg_valid,
	input  wire logic                             cfg_ready,
	input  wire logic [iirdf2_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [iirdf2_pkg::COEF_W-1:0]    cfg_data,
	output int unsigned                           mismatches,
	output int unsigned                           outstanding
);
	import iirdf2_pkg::*;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] y;
		logic                       last;
	} y_beat_t;

	localparam longint W_HI = (longint'(1) <<< (W_W - 1)) - 1;
	localparam longint W_LO = -(longint'(1) <<< (W_W - 1));
	localparam longint Y_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint Y_LO = -(longint'(1) <<< (SAMPLE_W - 1));

	logic signed [COEF_W-1:0] b_coef [4];
	logic signed [COEF_W-1:0] a_coef [4];
	logic signed [W_W-1:0]    w_ring [TAPS];
	int                       ring_pos;
	y_beat_t                  y_due [$];
	y_beat_t                  due;
	int unsigned              err_cnt = 0;

	function automatic longint round_q13(input longint acc);
		return (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// one sample through the filter: feedback sum, w write, feedforward sum
	function automatic y_beat_t filter_sample(input logic signed [SAMPLE_W-1:0] x,
			input logic last);
		longint  acc;
		longint  wv;
		int      head;
		int      k;
		y_beat_t r;
		head = TAPS - 1 - ring_pos;
		acc = longint'(x) <<< FRAC_BITS;
		for (k = 1; k < TAPS && k < 4; k++)
			acc -= longint'(a_coef[k]) * longint'(w_ring[(head + k) % TAPS]);
		wv = clamp(round_q13(acc), W_LO, W_HI);
		w_ring[head] = wv[W_W-1:0];
		acc = 0;
		for (k = 0; k < TAPS && k < 4; k++)
			acc += longint'(b_coef[k]) * longint'(w_ring[(head + k) % TAPS]);
		wv = clamp(round_q13(acc), Y_LO, Y_HI);
		r.y = wv[SAMPLE_W-1:0];
		r.last = last;
		ring_pos = (ring_pos + 1) % TAPS;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				b_coef[i] = '0;
				a_coef[i] = '0;
			end
			b_coef[0] = NUM0_RESET;
			for (int i = 0; i < TAPS; i++)
				w_ring[i] = '0;
			ring_pos = 0;
			y_due.delete();
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index <= CFG_NUM3)
					b_coef[cfg_index[1:0]] = cfg_data;
				else if (cfg_index <= CFG_LAST)
					a_coef[2'(cfg_index - CFG_DEN1 + 3'd1)] = cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (y_due.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: result beat with none due: sample_out %0d block_end_out %0b",
							$time, $signed(m_axis_tdata), m_axis_tlast);
				end else begin
					due = y_due.pop_front();
					if (due.y !== m_axis_tdata || due.last !== m_axis_tlast) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("%0t: sample_out exp %0d got %0d, block_end_out exp %0b got %0b",
								$time, due.y, $signed(m_axis_tdata), due.last, m_axis_tlast);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				y_due.push_back(filter_sample(s_axis_tdata, s_axis_tlast));
			outstanding <= y_due.size();
			mismatches <= err_cnt;
		end
	end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the direct form II filter core with directed samples at the field
// extremes and rounding ties under reset, extreme and half gain coefficient
// sets, then with random samples over a series of random coefficient sets.
// Both stream sides idle at random; results are checked by iirdf2_check.
// ----------------------------------------------------------------------------
module tb_top;
	import iirdf2_pkg::*;

	localparam int          LIMIT_CYCLES = 600000;
	localparam int          RAND_PHASES  = 10;
	localparam int          PHASE_BEATS  = 110;
	localparam logic [15:0] C_MAX        = 16'h7FFF;
	localparam logic [15:0] C_MIN        = 16'h8000;
	localparam logic [15:0] C_HALF       = 16'd4096;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_LAST + 3'd1;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata;
	logic                 s_axis_tlast;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [15:0]          m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;
	int unsigned          mismatches;
	int unsigned          outstanding;
	logic                 tx_calm;
	logic                 rx_calm;

	always #6 clk = ~clk;

	iir_direct_form_two_filter_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	iirdf2_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	task automatic push_sample(input logic [15:0] x, input logic last);
		int gap;
		if ($urandom_range(0, 31) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= x;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_filter(input logic [COEF_W-1:0] cs [7]);
		drain_results();
		repeat (12) @(posedge clk);
		for (int i = 0; i < 7; i++)
			write_coef(CFG_NUM0 + CFG_IDX_W'(i), cs[i]);
		if ($urandom_range(0, 1) == 0)
			write_coef(CFG_UNUSED, 16'($urandom_range(0, 65535)));
	endtask

	function automatic logic [COEF_W-1:0] draw_coef(input int style, input bit feedback);
		case (style)
			0: return 16'($urandom_range(0, 65535));
			1: return feedback ? 16'($urandom_range(0, 6144)) - 16'd3072
				: 16'($urandom_range(0, 24576)) - 16'd12288;
			default: begin
				case ($urandom_range(0, 4))
					0: return C_MAX;
					1: return C_MIN;
					2: return 16'd8192;
					3: return 16'hE000;
					default: return 16'd0;
				endcase
			end
		endcase
	endfunction

	function automatic logic [15:0] draw_sample();
		case ($urandom_range(0, 19))
			0: return C_MAX;
			1: return C_MIN;
			2: return 16'd0;
			3, 4, 5: return 16'($urandom_range(0, 512)) - 16'd256;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		#(12 * LIMIT_CYCLES);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		rx_calm = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		logic [COEF_W-1:0] cs [7];
		int                style;
		arst_n = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= CFG_NUM0;
		cfg_data      <= '0;
		tx_calm = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients pass samples straight through
		push_sample(C_MAX, 1'b0);
		push_sample(C_MIN, 1'b0);
		push_sample(16'd0, 1'b1);
		push_sample(16'd1, 1'b0);
		push_sample(16'hFFFF, 1'b1);

		// runaway feedback: w and y saturate high
		cs = '{C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN};
		program_filter(cs);
		repeat (4) push_sample(C_MAX, 1'b0);
		push_sample(C_MIN, 1'b1);
		push_sample(C_MIN, 1'b0);

		// alternating feedback: saturate both ways
		cs = '{C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX};
		program_filter(cs);
		push_sample(C_MIN, 1'b0);
		push_sample(C_MAX, 1'b1);
		push_sample(16'd100, 1'b0);
		push_sample(16'hFF9C, 1'b0);
		push_sample(16'd0, 1'b0);
		push_sample(16'd0, 1'b1);

		// half gain: rounding ties go upward
		cs = '{C_HALF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
		program_filter(cs);
		push_sample(16'd1, 1'b0);
		push_sample(16'hFFFF, 1'b0);
		push_sample(16'd3, 1'b0);
		push_sample(16'hFFFD, 1'b1);

		for (int p = 0; p < RAND_PHASES; p++) begin
			style = p % 3;
			for (int i = 0; i < 7; i++)
				cs[i] = draw_coef(style, i > 3);
			program_filter(cs);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				push_sample(draw_sample(), $urandom_range(0, 7) == 0);
				if ($urandom_range(0, 63) == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (30) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
src/iirdf2_pkg.sv
src/iirdf2_seq.sv
src/iirdf2_dp.sv
src/iirdf2_filter_core.sv
bench/iirdf2_check.sv
bench/tb_top.sv
